// File: sv/ioe_pkg.sv
// Shared types and constants for the indexed ordered list engine.
// Used by ioe_ctrl, ioe_dpath and indexed_ordered_list_engine; no dependencies.
package ioe_pkg;

  // Default number of elements the list can hold.
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_IDX  = 3'd2,
    ACT_REM_HEAD = 3'd3,
    ACT_REM_TAIL = 3'd4,
    ACT_REM_IDX  = 3'd5,
    ACT_DUMP     = 3'd6,
    ACT_NOP      = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    action_t            action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] element;
    logic               has_element;
    logic [4:0]         entries;
    logic               last;
  } rsp_t;

  typedef enum logic {
    CS_IDLE,
    CS_DUMP
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;        // carry out the accepted command and load its result
    logic dump_start;  // load the dump counter with the element count
    logic dump_step;   // emit the head element and rotate the list by one
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // result register can take a new beat this cycle
    logic count_zero;  // list holds no elements
    logic dump_last;   // the next dump beat is the final one
  } dp_sts_t;

endpackage

// File: sv/ioe_ctrl.sv
// Controller state machine of the indexed ordered list engine.
// Depends on ioe_pkg for the state, command and status types.
module ioe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  ioe_pkg::action_t  action,
  output logic              cmd_stall,
  output ioe_pkg::dp_ctl_t  ctl,
  input  ioe_pkg::dp_sts_t  sts
);

  ioe_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ioe_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = 1'b1;
    unique case (state)
      ioe_pkg::CS_IDLE: begin
        cmd_stall = !sts.out_free;
        if (cmd_valid && sts.out_free) begin
          // A dump of a non-empty list walks the elements; anything else
          // finishes in the accepting cycle.
          if (action == ioe_pkg::ACT_DUMP && !sts.count_zero) begin
            ctl.dump_start = 1'b1;
            state_next     = ioe_pkg::CS_DUMP;
          end else begin
            ctl.exec = 1'b1;
          end
        end
      end
      ioe_pkg::CS_DUMP: begin
        if (sts.out_free) begin
          ctl.dump_step = 1'b1;
          if (sts.dump_last) begin
            state_next = ioe_pkg::CS_IDLE;
          end
        end
      end
      default: begin
        state_next = ioe_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ioe_dpath.sv
// Datapath of the indexed ordered list engine: shift array, count and result register.
// Depends on ioe_pkg for the payload, command and status types.
module ioe_dpath #(
  parameter int CAPACITY = ioe_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ioe_pkg::cmd_t     cmd,
  input  ioe_pkg::dp_ctl_t  ctl,
  output ioe_pkg::dp_sts_t  sts,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ioe_pkg::rsp_t     rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  logic [31:0]      store [CAPACITY];
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] remaining;

  logic [CMP_W-1:0] pos_c, cnt_c, cap_c, tgt, cnt_m1;
  logic             is_ins, is_rem, do_ins, do_rem;
  ioe_pkg::status_t status;

  assign pos_c  = CMP_W'(cmd.position);
  assign cnt_c  = CMP_W'(count);
  assign cap_c  = CMP_W'(CAPACITY);
  assign cnt_m1 = cnt_c - CMP_W'(1);

  // Decode the command into a target index and a status.
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    tgt    = '0;
    status = ioe_pkg::ST_OK;
    unique case (cmd.action)
      ioe_pkg::ACT_INS_HEAD: begin
        is_ins = 1'b1;
      end
      ioe_pkg::ACT_INS_TAIL: begin
        is_ins = 1'b1;
        tgt    = cnt_c;
      end
      ioe_pkg::ACT_INS_IDX: begin
        is_ins = 1'b1;
        tgt    = pos_c;
      end
      ioe_pkg::ACT_REM_HEAD: begin
        is_rem = 1'b1;
      end
      ioe_pkg::ACT_REM_TAIL: begin
        is_rem = 1'b1;
        tgt    = cnt_m1;
      end
      ioe_pkg::ACT_REM_IDX: begin
        is_rem = 1'b1;
        tgt    = pos_c;
      end
      ioe_pkg::ACT_DUMP, ioe_pkg::ACT_NOP: begin
        is_ins = 1'b0;
      end
    endcase
    if (is_ins) begin
      if (tgt > cnt_c) begin
        status = ioe_pkg::ST_BOUNDS;
      end else if (cnt_c >= cap_c) begin
        status = ioe_pkg::ST_FULL;
      end
    end else if (is_rem) begin
      // An empty list fails head and tail removal as empty; an index
      // removal past the end fails as out of bounds.
      if (count == '0 || tgt >= cnt_c) begin
        status = (cmd.action == ioe_pkg::ACT_REM_IDX) ? ioe_pkg::ST_BOUNDS
                                                      : ioe_pkg::ST_EMPTY;
      end
    end
  end

  assign do_ins = ctl.exec && is_ins && status == ioe_pkg::ST_OK;
  assign do_rem = ctl.exec && is_rem && status == ioe_pkg::ST_OK;

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Each entry sees its neighbors and entry 0: insert shifts up, remove shifts
  // down, and a dump step rotates the occupied part down by one.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
    localparam logic [CMP_W-1:0] GI = CMP_W'(g);
    logic [31:0] prv, nxt;
    if (g > 0) begin : g_prv
      assign prv = store[g-1];
    end else begin : g_prv0
      assign prv = store[g];
    end
    if (g < CAPACITY - 1) begin : g_nxt
      assign nxt = store[g+1];
    end else begin : g_nxt_end
      assign nxt = store[g];
    end
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (GI > tgt) begin
          store[g] <= prv;
        end else if (GI == tgt) begin
          store[g] <= cmd.value;
        end
      end else if (do_rem) begin
        if (GI >= tgt) begin
          store[g] <= nxt;
        end
      end else if (ctl.dump_step) begin
        if (GI == cnt_m1) begin
          store[g] <= store[0];
        end else if (GI < cnt_m1) begin
          store[g] <= nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remaining <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (ctl.dump_start) begin
        remaining <= count;
      end else if (ctl.dump_step) begin
        remaining <= remaining - CNT_W'(1);
      end
      if (ctl.exec || ctl.dump_step) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      rsp.status      <= status;
      rsp.element     <= '0;
      rsp.has_element <= 1'b0;
      rsp.entries     <= 5'(count_next);
      rsp.last        <= 1'b1;
    end else if (ctl.dump_step) begin
      rsp.status      <= ioe_pkg::ST_OK;
      rsp.element     <= store[0];
      rsp.has_element <= 1'b1;
      rsp.entries     <= 5'(count);
      rsp.last        <= (remaining == CNT_W'(1));
    end
  end

  assign sts.out_free   = !rsp_valid || !rsp_stall;
  assign sts.count_zero = (count == '0);
  assign sts.dump_last  = (remaining == CNT_W'(1));

endmodule

// File: sv/indexed_ordered_list_engine.sv
// Indexed ordered list engine: a bounded ordered list of signed 32-bit values.
// An accepted command's result is registered and offered as a beat in the next cycle; a
// dump of N > 0 elements first loads its counter, then sends one beat per cycle while the
// receiver does not stall. Throughput: one command per cycle while the receiver does not
// stall; a dump holds off new commands until its last beat is loaded.
// Reset clears the count and handshake state; entry contents are left as they are.
module indexed_ordered_list_engine #(
  parameter int CAPACITY = ioe_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ioe_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ioe_pkg::rsp_t rsp
);

  // The controller decides, beat by beat, whether the datapath executes an
  // accepted command, starts a dump or emits the next dumped element. The
  // datapath reports back whether its result register is free, whether the
  // list is empty and whether the current dump beat is the final one.
  ioe_pkg::dp_ctl_t ctl;
  ioe_pkg::dp_sts_t sts;

  // The controller only runs the state machine and the input handshake.
  ioe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .action    (cmd.action),
    .cmd_stall (cmd_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // The datapath holds the entries as a shift array, so every insert and
  // remove completes in the cycle that accepts it. A dump rotates the
  // occupied entries through the head and restores the original order once
  // all elements have been sent. The result register decouples the two
  // channels, so a new command is taken in the cycle its predecessor's
  // beat leaves.
  ioe_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: sim/tb_indexed_ordered_list_engine.sv
// Self-checking testbench for indexed_ordered_list_engine: directed corner cases, then random
// command traffic under several idling patterns, checked beat by beat against a local list model.
// Depends on ioe_pkg and the indexed_ordered_list_engine RTL.
module tb_indexed_ordered_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = ioe_pkg::CAPACITY_DEF;
  // The limit leaves a wide margin over the slowest run.
  localparam int CYCLE_LIMIT = 200000;
  // Long enough for a dump of a full list, so this covers any trailing beat.
  localparam int TAIL_CYCLES = CAPACITY + 8;
  localparam int PRINT_CAP   = 40;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_stall;
  ioe_pkg::cmd_t  cmd       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  ioe_pkg::rsp_t  rsp;

  indexed_ordered_list_engine #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // Local copy of the list: the stored values in order and how many there are.
  logic signed [31:0] list_store [CAPACITY];
  int                 list_count = 0;

  // Result beats that the accepted commands must still produce, oldest first.
  ioe_pkg::rsp_t rsp_due [$];
  ioe_pkg::rsp_t want_rsp;

  int   error_count = 0;
  int   cycle_count = 0;
  int   cmds_sent   = 0;
  int   beats_seen  = 0;
  int   dumps_sent  = 0;
  int   full_hits   = 0;

  // Idling controls, in percent of cycles. The stimulus sets them per phase.
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;

  // Random inserts lean toward filling the list until it is full, then toward draining it.
  bit   fill_bias = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // The cycle counter doubles as the watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles with %0d beats outstanding",
               cycle_count, rsp_due.size());
      $display("tb_indexed_ordered_list_engine: errors");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Every accepted result beat is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      beats_seen++;
      if (rsp_due.size() == 0) begin
        report_error($sformatf("beat %0d arrived with no beat expected", beats_seen));
      end else begin
        want_rsp = rsp_due.pop_front();
        if (rsp.status !== want_rsp.status) begin
          report_error($sformatf("beat %0d status %0d, expected %s", beats_seen,
                                 rsp.status, want_rsp.status.name()));
        end
        if (rsp.element !== want_rsp.element) begin
          report_error($sformatf("beat %0d element %0d, expected %0d", beats_seen,
                                 rsp.element, want_rsp.element));
        end
        if (rsp.has_element !== want_rsp.has_element) begin
          report_error($sformatf("beat %0d has_element %b, expected %b", beats_seen,
                                 rsp.has_element, want_rsp.has_element));
        end
        if (rsp.entries !== want_rsp.entries) begin
          report_error($sformatf("beat %0d entries %0d, expected %0d", beats_seen,
                                 rsp.entries, want_rsp.entries));
        end
        if (rsp.last !== want_rsp.last) begin
          report_error($sformatf("beat %0d last %b, expected %b", beats_seen,
                                 rsp.last, want_rsp.last));
        end
      end
    end
  end

  function automatic void push_rsp(input ioe_pkg::status_t st,
                                   input logic signed [31:0] elem,
                                   input logic has, input logic fin);
    ioe_pkg::rsp_t r;
    r.status      = st;
    r.element     = elem;
    r.has_element = has;
    r.entries     = list_count[4:0];
    r.last        = fin;
    rsp_due.push_back(r);
  endfunction

  // Insert into the local list. A position past the count is refused before the
  // full check, so a full list still reports out of bounds for such a position.
  function automatic ioe_pkg::status_t list_put(input int pos, input logic signed [31:0] v);
    if (pos > list_count) return ioe_pkg::ST_BOUNDS;
    if (list_count >= CAPACITY) begin
      full_hits++;
      return ioe_pkg::ST_FULL;
    end
    for (int i = list_count; i > pos; i--) list_store[i] = list_store[i - 1];
    list_store[pos] = v;
    list_count++;
    return ioe_pkg::ST_OK;
  endfunction

  function automatic void list_take(input int pos);
    for (int i = pos; i + 1 < list_count; i++) list_store[i] = list_store[i + 1];
    list_count--;
  endfunction

  // Applies one accepted command to the local list and queues the beats it must produce.
  function automatic void list_apply(input ioe_pkg::cmd_t c);
    ioe_pkg::status_t st;
    st = ioe_pkg::ST_OK;
    case (c.action)
      ioe_pkg::ACT_INS_HEAD: st = list_put(0, c.value);
      ioe_pkg::ACT_INS_TAIL: st = list_put(list_count, c.value);
      ioe_pkg::ACT_INS_IDX:  st = list_put(int'(c.position), c.value);
      ioe_pkg::ACT_REM_HEAD: begin
        if (list_count == 0) st = ioe_pkg::ST_EMPTY;
        else list_take(0);
      end
      ioe_pkg::ACT_REM_TAIL: begin
        if (list_count == 0) st = ioe_pkg::ST_EMPTY;
        else list_take(list_count - 1);
      end
      ioe_pkg::ACT_REM_IDX: begin
        if (int'(c.position) >= list_count) st = ioe_pkg::ST_BOUNDS;
        else list_take(int'(c.position));
      end
      ioe_pkg::ACT_DUMP: begin
        dumps_sent++;
        // An empty list still answers a dump with one closing beat.
        if (list_count == 0) begin
          push_rsp(ioe_pkg::ST_OK, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < list_count; i++) begin
            push_rsp(ioe_pkg::ST_OK, list_store[i], 1'b1, (i + 1 == list_count));
          end
        end
        return;
      end
      default: ;  // the unused code leaves the list alone and answers ok
    endcase
    push_rsp(st, '0, 1'b0, 1'b1);
  endfunction

  // Sends one command beat. Valid stays high after the beat so that a following
  // call in the same time step continues without a gap.
  task automatic send_cmd(input ioe_pkg::action_t act, input logic [4:0] pos,
                          input logic signed [31:0] v);
    ioe_pkg::cmd_t c;
    c.action   = act;
    c.position = pos;
    c.value    = v;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    list_apply(c);
    cmds_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Position for an insert: mostly a legal slot, sometimes anywhere in the field.
  function automatic logic [4:0] pick_ins_pos();
    if ($urandom_range(99) < 85) return 5'($urandom_range(list_count));
    return 5'($urandom_range(31));
  endfunction

  function automatic logic [4:0] pick_rem_pos();
    if (list_count > 0 && $urandom_range(99) < 85) return 5'($urandom_range(list_count - 1));
    return 5'($urandom_range(31));
  endfunction

  // Empty list refusals, the unused code, inserts of extreme values at each end
  // and in the middle, dumps, and removals by every route.
  task automatic test_directed();
    send_cmd(ioe_pkg::ACT_DUMP,     5'd0,  '0);
    send_cmd(ioe_pkg::ACT_REM_HEAD, 5'd0,  '0);
    send_cmd(ioe_pkg::ACT_REM_TAIL, 5'd0,  '0);
    send_cmd(ioe_pkg::ACT_REM_IDX,  5'd0,  '0);
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'd1,  32'sd5);
    send_cmd(ioe_pkg::ACT_NOP,      5'd31, 32'sh7fff_ffff);
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'd0,  32'sh1234_5678);
    send_cmd(ioe_pkg::ACT_INS_HEAD, 5'd31, 32'sh7fff_ffff);
    send_cmd(ioe_pkg::ACT_INS_TAIL, 5'd0,  32'sh8000_0000);
    // Position equal to the count appends at the tail.
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'd3,  -32'sd1);
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'd2,  32'sd0);
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'd31, 32'sd9);
    send_cmd(ioe_pkg::ACT_NOP,      5'd0,  '0);
    send_cmd(ioe_pkg::ACT_DUMP,     5'd0,  '0);
    send_cmd(ioe_pkg::ACT_REM_IDX,  5'd31, '0);
    send_cmd(ioe_pkg::ACT_REM_IDX,  5'd5,  '0);
    send_cmd(ioe_pkg::ACT_REM_IDX,  5'd2,  '0);
    send_cmd(ioe_pkg::ACT_REM_HEAD, 5'd0,  '0);
    send_cmd(ioe_pkg::ACT_REM_TAIL, 5'd0,  '0);
    send_cmd(ioe_pkg::ACT_DUMP,     5'd0,  '0);
    send_cmd(ioe_pkg::ACT_REM_IDX,  5'd0,  '0);
    send_cmd(ioe_pkg::ACT_DUMP,     5'd0,  '0);
  endtask

  // Fills the list to capacity, probes every insert against the full list, dumps
  // it whole, and then empties it again by random removals.
  task automatic test_full_list();
    while (list_count < CAPACITY) begin
      case ($urandom_range(2))
        0:       send_cmd(ioe_pkg::ACT_INS_HEAD, 5'($urandom), pick_value());
        1:       send_cmd(ioe_pkg::ACT_INS_TAIL, 5'($urandom), pick_value());
        default: send_cmd(ioe_pkg::ACT_INS_IDX, 5'($urandom_range(list_count)), pick_value());
      endcase
    end
    send_cmd(ioe_pkg::ACT_INS_HEAD, 5'd0,  32'sd1);
    send_cmd(ioe_pkg::ACT_INS_TAIL, 5'd0,  32'sd2);
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'(CAPACITY), 32'sd3);
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'(CAPACITY + 1), 32'sd4);
    send_cmd(ioe_pkg::ACT_REM_IDX,  5'(CAPACITY), '0);
    send_cmd(ioe_pkg::ACT_DUMP,     5'd0,  '0);
    send_cmd(ioe_pkg::ACT_REM_IDX,  5'(CAPACITY - 1), '0);
    send_cmd(ioe_pkg::ACT_INS_IDX,  5'(CAPACITY - 1), 32'sh8000_0000);
    send_cmd(ioe_pkg::ACT_DUMP,     5'd0,  '0);
    while (list_count > 0) begin
      case ($urandom_range(2))
        0:       send_cmd(ioe_pkg::ACT_REM_HEAD, 5'($urandom), '0);
        1:       send_cmd(ioe_pkg::ACT_REM_TAIL, 5'($urandom), '0);
        default: send_cmd(ioe_pkg::ACT_REM_IDX, 5'($urandom_range(list_count - 1)), '0);
      endcase
    end
    send_cmd(ioe_pkg::ACT_DUMP, 5'd0, '0);
  endtask

  // Random traffic that swings the list between empty and full, with dumps and
  // stray codes sprinkled in, under one idling pattern.
  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    int roll;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (list_count == CAPACITY) fill_bias = 1'b0;
      else if (list_count == 0) fill_bias = 1'b1;
      else if ($urandom_range(99) < 3) fill_bias = ~fill_bias;
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_cmd(ioe_pkg::ACT_DUMP, 5'($urandom), pick_value());
      end else if (roll < 10) begin
        send_cmd(ioe_pkg::ACT_NOP, 5'($urandom), pick_value());
      end else if ((roll < 75) == fill_bias) begin
        case ($urandom_range(2))
          0:       send_cmd(ioe_pkg::ACT_INS_HEAD, 5'($urandom), pick_value());
          1:       send_cmd(ioe_pkg::ACT_INS_TAIL, 5'($urandom), pick_value());
          default: send_cmd(ioe_pkg::ACT_INS_IDX, pick_ins_pos(), pick_value());
        endcase
      end else begin
        case ($urandom_range(2))
          0:       send_cmd(ioe_pkg::ACT_REM_HEAD, 5'($urandom), pick_value());
          1:       send_cmd(ioe_pkg::ACT_REM_TAIL, 5'($urandom), pick_value());
          default: send_cmd(ioe_pkg::ACT_REM_IDX, pick_rem_pos(), pick_value());
        endcase
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_list();
    test_random_traffic(80, 0, 0);
    test_random_traffic(80, 58, 0);
    test_random_traffic(80, 0, 58);
    test_random_traffic(80, 37, 37);

    // Stop sending and let every expected beat come out, then watch for strays.
    cmd_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d dumps, %0d refused as full), checked %0d result beats,",
             cmds_sent, dumps_sent, full_hits, beats_seen);
    $display("across four idling phases from a free-running link %s",
             "to heavy sender and receiver idling.");
    if (error_count == 0 && rsp_due.size() == 0) begin
      $display("tb_indexed_ordered_list_engine: clean");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", error_count, rsp_due.size());
      $display("tb_indexed_ordered_list_engine: errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ioe_pkg.sv
sv/ioe_ctrl.sv
sv/ioe_dpath.sv
sv/indexed_ordered_list_engine.sv
sim/tb_indexed_ordered_list_engine.sv
